### rtl/core/fuaf_pkg.sv
// Shared types and codes of the face upwind advection flux block.
`default_nettype none

package fuaf_pkg;

  localparam int CFG_AW = 2;
  localparam int S_TUSER_W = 4;

  typedef enum logic [CFG_AW-1:0] {
    REG_VEL_X = 2'd0,
    REG_VEL_Y = 2'd1,
    REG_VEL_Z = 2'd2,
    REG_BND_VAL = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_SINE = 2'd1,
    KIND_OPENING = 2'd2,
    KIND_WALL = 2'd3
  } bnd_kind_t;

  typedef enum logic [2:0] {
    OP_INNER = 3'd0,
    OP_OUTER = 3'd1,
    OP_DOT_X = 3'd2,
    OP_DOT_Y = 3'd3,
    OP_DOT_Z = 3'd4,
    OP_FLUX_X = 3'd5,
    OP_FLUX_Y = 3'd6,
    OP_FLUX_Z = 3'd7
  } op_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOAD = 6'b000010,
    S_MLO = 6'b000100,
    S_MHI = 6'b001000,
    S_WB = 6'b010000,
    S_OUT = 6'b100000
  } state_t;

  typedef struct packed {
    logic load;
    logic lo;
    logic hi;
  } mul_ctl_t;

endpackage

`default_nettype wire

### rtl/core/fuaf_mul.sv
// Shared fixed point multiplier: two half-width passes, truncation and saturation.
`default_nettype none

module fuaf_mul #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                         clk,
  input  wire fuaf_pkg::mul_ctl_t           ctl,
  input  wire logic signed [DATA_WIDTH-1:0] a,
  input  wire logic signed [DATA_WIDTH-1:0] b,
  output logic signed [DATA_WIDTH-1:0]      res,
  output logic                              clip
);
  import fuaf_pkg::*;

  localparam int DW = DATA_WIDTH;
  localparam int HB = (DW + 1) / 2;
  localparam int PW = 2 * DW;

  logic [DW-1:0]    mag_a;
  logic [DW-1:0]    mag_b;
  logic             neg;
  logic [PW-1:0]    prod;
  logic [HB-1:0]    b_part;
  logic [DW+HB-1:0] pp;
  logic [PW-1:0]    q;
  logic [DW-1:0]    lim;
  logic [DW-1:0]    qs;

  assign b_part = ctl.hi ? HB'(mag_b[DW-1:HB]) : mag_b[HB-1:0];
  assign pp = mag_a * b_part;

  always_ff @(posedge clk) begin
    priority if (ctl.load) begin
      mag_a <= a[DW-1] ? DW'(-a) : DW'(a);
      mag_b <= b[DW-1] ? DW'(-b) : DW'(b);
      neg <= a[DW-1] ^ b[DW-1];
    end else if (ctl.lo) begin
      prod <= PW'(pp);
    end else if (ctl.hi) begin
      prod <= prod + (PW'(pp) << HB);
    end
  end

  assign q = prod >> FRAC_BITS;
  assign lim = {neg, {(DW-1){~neg}}};
  assign clip = q > PW'(lim);
  assign qs = clip ? lim : q[DW-1:0];
  assign res = neg ? -$signed(qs) : $signed(qs);

endmodule

`default_nettype wire

### rtl/core/face_upwind_advection_flux.sv
// Top level of the face upwind advection flux block: sequencer, accumulators and ports.
// Every product runs on the shared multiplier through S_LOAD, S_MLO, S_MHI and S_WB; an item is taken in an idle cycle.
// A term that is not last forms the inner trace product, and the outer one when the outer node is present.
// A last term forms the traces, three dot products, three flux products when the face takes a value, then emit.
// The result word is held in an output register until it is taken.
// Synchronous reset clears the sequencer, the configuration registers, the traces and the clip flag.
`default_nettype none

module face_upwind_advection_flux #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS = 16,
  localparam int S_TDATA_W = ((6 * DATA_WIDTH + 7) / 8) * 8,
  localparam int M_TDATA_W = ((3 * DATA_WIDTH + 7) / 8) * 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [fuaf_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire logic [DATA_WIDTH-1:0]         cfg_data,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // Fields from the lowest bit: inner_node_value, outer_node_value, basis_weight,
  // normal_x, normal_y, normal_z, zero padding.
  input  wire logic [S_TDATA_W-1:0]          s_tdata,
  // Fields from the lowest bit: outer_present, has_neighbour, boundary_kind.
  input  wire logic [fuaf_pkg::S_TUSER_W-1:0] s_tuser,
  input  wire logic                          s_tlast,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // Fields from the lowest bit: flux_x, flux_y, flux_z, zero padding.
  output logic [M_TDATA_W-1:0]               m_tdata,
  // Fields from the lowest bit: saturated.
  output logic [0:0]                         m_tuser
);
  import fuaf_pkg::*;

  localparam int DW = DATA_WIDTH;

  function automatic logic [DW:0] qadd(input logic signed [DW-1:0] x,
                                       input logic signed [DW-1:0] y);
    logic signed [DW:0] s;
    logic [DW:0] r;
    s = {x[DW-1], x} + {y[DW-1], y};
    if (s[DW] != s[DW-1]) begin
      r = {1'b1, s[DW], {(DW-1){~s[DW]}}};
    end else begin
      r = {1'b0, s[DW-1:0]};
    end
    return r;
  endfunction

  state_t state;
  state_t state_next;
  op_t    op;
  op_t    op_next;

  logic signed [DW-1:0] vel_x, vel_y, vel_z, bnd_val;
  logic signed [DW-1:0] cap_inner, cap_outer, cap_w, cap_nx, cap_ny, cap_nz;
  logic                 cap_present, cap_nb, cap_last;
  bnd_kind_t            cap_kind;

  logic signed [DW-1:0] inner_sum, outer_sum, d_acc, u_val;
  logic signed [DW-1:0] p_x, p_y, p_z, f_x, f_y, f_z;
  logic                 clip;
  logic                 use_u;

  mul_ctl_t             mctl;
  logic signed [DW-1:0] mul_a, mul_b, mul_res;
  logic                 mul_clip;
  logic signed [DW-1:0] add_a;
  logic [DW:0]          add_r;
  logic signed [DW-1:0] d_new;
  logic signed [DW-1:0] u_sel;
  logic                 use_sel;
  logic                 s_fire;
  logic                 emit;

  assign s_tready = (state == S_IDLE);
  assign s_fire = s_tvalid && s_tready;
  assign emit = (state == S_OUT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      vel_x <= '0;
      vel_y <= '0;
      vel_z <= '0;
      bnd_val <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_VEL_X: vel_x <= cfg_data;
        REG_VEL_Y: vel_y <= cfg_data;
        REG_VEL_Z: vel_z <= cfg_data;
        REG_BND_VAL: bnd_val <= cfg_data;
        default: vel_x <= vel_x;
      endcase
    end
  end

  always_comb begin
    mctl.load = (state == S_LOAD);
    mctl.lo = (state == S_MLO);
    mctl.hi = (state == S_MHI);
    unique case (op)
      OP_INNER: begin mul_a = cap_inner; mul_b = cap_w; end
      OP_OUTER: begin mul_a = cap_outer; mul_b = cap_w; end
      OP_DOT_X: begin mul_a = vel_x; mul_b = cap_nx; end
      OP_DOT_Y: begin mul_a = vel_y; mul_b = cap_ny; end
      OP_DOT_Z: begin mul_a = vel_z; mul_b = cap_nz; end
      OP_FLUX_X: begin mul_a = p_x; mul_b = u_val; end
      OP_FLUX_Y: begin mul_a = p_y; mul_b = u_val; end
      OP_FLUX_Z: begin mul_a = p_z; mul_b = u_val; end
      default: begin mul_a = cap_inner; mul_b = cap_w; end
    endcase
  end

  fuaf_mul #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk(clk),
    .ctl(mctl),
    .a(mul_a),
    .b(mul_b),
    .res(mul_res),
    .clip(mul_clip)
  );

  always_comb begin
    unique case (op)
      OP_INNER: add_a = inner_sum;
      OP_OUTER: add_a = outer_sum;
      default: add_a = d_acc;
    endcase
    add_r = qadd(add_a, mul_res);
    d_new = $signed(add_r[DW-1:0]);
    use_sel = 1'b1;
    if (cap_nb) begin
      u_sel = (d_new >= 0) ? inner_sum : outer_sum;
    end else begin
      unique case (cap_kind)
        KIND_SINE: u_sel = bnd_val;
        KIND_OPENING: u_sel = inner_sum;
        default: begin
          u_sel = '0;
          use_sel = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    op_next = op;
    unique case (state)
      S_IDLE: begin
        if (s_fire) begin
          state_next = S_LOAD;
          op_next = OP_INNER;
        end
      end
      S_LOAD: state_next = S_MLO;
      S_MLO: state_next = S_MHI;
      S_MHI: state_next = S_WB;
      S_WB: begin
        state_next = S_LOAD;
        unique case (op)
          OP_INNER: begin
            if (cap_present) begin
              op_next = OP_OUTER;
            end else if (cap_last) begin
              op_next = OP_DOT_X;
            end else begin
              state_next = S_IDLE;
            end
          end
          OP_OUTER: begin
            if (cap_last) begin
              op_next = OP_DOT_X;
            end else begin
              state_next = S_IDLE;
            end
          end
          OP_DOT_X: op_next = OP_DOT_Y;
          OP_DOT_Y: op_next = OP_DOT_Z;
          OP_DOT_Z: begin
            if (use_sel) begin
              op_next = OP_FLUX_X;
            end else begin
              state_next = S_OUT;
            end
          end
          OP_FLUX_X: op_next = OP_FLUX_Y;
          OP_FLUX_Y: op_next = OP_FLUX_Z;
          OP_FLUX_Z: state_next = S_OUT;
          default: state_next = S_IDLE;
        endcase
      end
      S_OUT: begin
        if (emit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op <= OP_INNER;
      m_tvalid <= 1'b0;
      clip <= 1'b0;
      inner_sum <= '0;
      outer_sum <= '0;
      d_acc <= '0;
    end else begin
      state <= state_next;
      op <= op_next;
      if (m_tvalid && m_tready && !emit) begin
        m_tvalid <= 1'b0;
      end
      if (state == S_WB) begin
        unique case (op)
          OP_INNER: begin
            inner_sum <= $signed(add_r[DW-1:0]);
            clip <= clip | mul_clip | add_r[DW];
          end
          OP_OUTER: begin
            outer_sum <= $signed(add_r[DW-1:0]);
            clip <= clip | mul_clip | add_r[DW];
          end
          OP_DOT_X, OP_DOT_Y, OP_DOT_Z: begin
            d_acc <= d_new;
            clip <= clip | mul_clip | add_r[DW];
          end
          default: clip <= clip | mul_clip;
        endcase
      end
      if (emit) begin
        m_tvalid <= 1'b1;
        inner_sum <= '0;
        outer_sum <= '0;
        d_acc <= '0;
        clip <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      cap_inner <= s_tdata[DW-1:0];
      cap_outer <= s_tdata[2*DW-1:DW];
      cap_w <= s_tdata[3*DW-1:2*DW];
      cap_nx <= s_tdata[4*DW-1:3*DW];
      cap_ny <= s_tdata[5*DW-1:4*DW];
      cap_nz <= s_tdata[6*DW-1:5*DW];
      cap_present <= s_tuser[0];
      cap_nb <= s_tuser[1];
      cap_kind <= bnd_kind_t'(s_tuser[3:2]);
      cap_last <= s_tlast;
    end
    if (state == S_WB) begin
      unique case (op)
        OP_DOT_X: p_x <= mul_res;
        OP_DOT_Y: p_y <= mul_res;
        OP_DOT_Z: begin
          p_z <= mul_res;
          u_val <= u_sel;
          use_u <= use_sel;
          f_x <= '0;
          f_y <= '0;
          f_z <= '0;
        end
        OP_FLUX_X: f_x <= mul_res;
        OP_FLUX_Y: f_y <= mul_res;
        OP_FLUX_Z: f_z <= mul_res;
        default: p_x <= p_x;
      endcase
    end
    if (emit) begin
      m_tdata <= M_TDATA_W'({f_z, f_y, f_x});
      m_tuser[0] <= clip;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == S_LOAD && op == OP_INNER)
    else $error("accepted word did not start the inner trace product");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    emit |=> m_tvalid && inner_sum == '0 && outer_sum == '0 && !clip)
    else $error("emit did not present a result and clear the traces");

  a_outer_only_present: assert property (@(posedge clk) disable iff (rst)
    state == S_WB && op == OP_OUTER |-> cap_present)
    else $error("outer product formed without an outer node");

  a_flux_needs_use: assert property (@(posedge clk) disable iff (rst)
    state == S_LOAD && (op == OP_FLUX_X || op == OP_FLUX_Y || op == OP_FLUX_Z)
    |-> use_u && cap_last)
    else $error("flux product formed for a face that takes no trace");

  a_valid_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_OUT)
    else $error("result raised outside the emit state");

endmodule

`default_nettype wire
